// ===== sv/assert_macros.svh =====
// Assertion macros shared by the sparse matrix-vector core.
// Self-contained; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is held.
`define CSM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also evaluated during reset.
`define CSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/csm_pkg.sv =====
// Types and constants of the CSR sparse matrix-vector core.
// No dependencies; imported by every module of the core but csm_ram.
package csm_pkg;

  localparam int unsigned IndexW  = 12;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned RowsW   = 13;

  localparam logic [RowsW-1:0] ROWS_MAX = 13'd4096;

  // Action codes of an input item.
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_NONZERO = 2'd1;
  localparam logic [1:0] ACT_EMPTY   = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [IndexW-1:0]       index;
    logic signed [DataW-1:0] value;
    logic                    row_end;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0]       row_number;
    logic signed [DataW-1:0] row_sum;
    logic                    last_row;
    logic                    saturated;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic vec_write; // write the vector store at the item's index
    logic vec_read;  // read the vector store at the item's column
    logic mul;       // register coefficient times vector entry
    logic acc;       // add the product into the row accumulator
    logic finish;    // round, load the output register, advance the row
  } csm_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL   = 4'b0010,
    S_ACC   = 4'b0100,
    S_ROUND = 4'b1000
  } csm_state_t;

endpackage

// ===== sv/csr_sparse_matvec_core.sv =====
// Sequencing: a load is written when accepted; a nonzero passes through vector read,
// multiply and accumulate, then rounding if row_end is set; an empty row goes
// straight to rounding, which waits on a full, stalled output; the result is valid
// in the cycle after rounding. Nonzeros share the single multiply-accumulate path.
// Reset (rst, synchronous): accumulator and row counter clear, rows_in_use becomes 4096;
// the vector store is not cleared and must be loaded before use.
module csr_sparse_matvec_core #(
  parameter int unsigned VECTOR_DEPTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  csm_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output csm_pkg::out_item_t        out_item,
  input  logic                      cfg_write,
  input  logic [csm_pkg::RowsW-1:0] cfg_data
);
  import csm_pkg::*;

  csm_cmd_t cmd;
  logic     row_end_held;

  csm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_action   (in_item.action),
    .in_stall    (in_stall),
    .row_end_held(row_end_held),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  csm_datapath #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_item     (in_item),
    .cmd         (cmd),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .row_end_held(row_end_held),
    .out_item    (out_item)
  );

endmodule

// ===== sv/csm_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module csm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/csm_datapath.sv =====
// Datapath of the sparse matrix-vector core: vector store, multiplier,
// saturating accumulator, rounding, row counter and output register.
// Depends on csm_pkg and csm_ram.
module csm_datapath #(
  parameter int unsigned VECTOR_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  csm_pkg::in_item_t            in_item,
  input  csm_pkg::csm_cmd_t            cmd,
  input  logic                         cfg_write,
  input  logic [csm_pkg::RowsW-1:0]    cfg_data,
  output logic                         row_end_held,
  output csm_pkg::out_item_t           out_item
);
  import csm_pkg::*;

  localparam int unsigned AddrW = $clog2(VECTOR_DEPTH);

  logic                    in_range;
  logic                    in_range_r;
  logic signed [DataW-1:0] value_r;
  logic                    row_end_r;
  logic [DataW-1:0]        ram_rdata;
  logic signed [DataW-1:0] x_sel;
  logic signed [AccW-1:0]  prod;
  logic signed [AccW-1:0]  acc;
  logic [AccW:0]           sum_wide;
  logic signed [AccW-1:0]  acc_sum;
  logic [48:0]             q_wide;
  logic                    sat_hi;
  logic                    sat_lo;
  logic [DataW-1:0]        q_clip;
  logic [RowsW-1:0]        rows_in_use;
  logic [RowsW-1:0]        row_limit;
  logic [IndexW-1:0]       row_counter;
  logic [RowsW-1:0]        row_next;
  logic                    is_last;

  assign in_range = 32'(in_item.index) < 32'(VECTOR_DEPTH);

  csm_ram #(
    .WIDTH(DataW),
    .DEPTH(VECTOR_DEPTH)
  ) u_vec_ram (
    .clk  (clk),
    .we   (cmd.vec_write && in_range),
    .waddr(AddrW'(in_item.index)),
    .wdata(in_item.value),
    .re   (cmd.vec_read),
    .raddr(AddrW'(in_item.index)),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_range_r <= in_range;
      value_r    <= in_item.value;
      row_end_r  <= in_item.row_end;
    end
  end

  assign row_end_held = row_end_r;

  // A column past the end of the store multiplies by zero.
  assign x_sel = in_range_r ? $signed(ram_rdata) : '0;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= AccW'(value_r * x_sel);
    end
  end

  // Saturating 64-bit accumulate: overflow shows as a mismatch of the top two bits.
  assign sum_wide = {acc[AccW-1], acc} + {prod[AccW-1], prod};
  always_comb begin
    if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      acc_sum = sum_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sum = sum_wide[AccW-1:0];
    end
  end

  // Round Q32.32 to Q16.16, ties toward plus infinity, then clip to 32 bits.
  assign q_wide = {acc[AccW-1], acc[AccW-1:16]} + {48'd0, acc[15]};
  assign sat_hi = !q_wide[48] && (q_wide[47:31] != '0);
  assign sat_lo = q_wide[48] && (q_wide[47:31] != '1);
  always_comb begin
    priority if (sat_hi) begin
      q_clip = {1'b0, {(DataW-1){1'b1}}};
    end else if (sat_lo) begin
      q_clip = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      q_clip = q_wide[DataW-1:0];
    end
  end

  assign row_limit = (rows_in_use == '0 || rows_in_use > ROWS_MAX) ? ROWS_MAX : rows_in_use;
  assign row_next  = {1'b0, row_counter} + RowsW'(1);
  assign is_last   = row_next >= row_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      row_counter <= '0;
      rows_in_use <= ROWS_MAX;
    end else begin
      if (cfg_write) begin
        rows_in_use <= cfg_data;
      end
      priority if (cmd.finish) begin
        acc         <= '0;
        row_counter <= is_last ? '0 : row_next[IndexW-1:0];
      end else if (cmd.acc) begin
        acc <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.row_number <= row_counter;
      out_item.row_sum    <= q_clip;
      out_item.last_row   <= is_last;
      out_item.saturated  <= sat_hi || sat_lo;
    end
  end

endmodule

// ===== sv/csm_ctrl.sv =====
// Controller of the sparse matrix-vector core: item handshake, sequencing
// of read, multiply, accumulate and finish, and the output valid flag.
// Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module csm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  output logic              in_stall,
  input  logic              row_end_held,
  output csm_pkg::csm_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_stall
);
  import csm_pkg::*;

  csm_state_t state;
  csm_state_t state_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.capture    = accept;
    cmd.vec_write  = accept && (in_action == ACT_LOAD);
    cmd.vec_read   = accept && (in_action == ACT_NONZERO);
    unique case (state)
      S_IDLE: begin
        if (accept && in_action == ACT_NONZERO) begin
          state_next = S_MUL;
        end else if (accept && in_action == ACT_EMPTY) begin
          state_next = S_ROUND;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = row_end_held ? S_ROUND : S_IDLE;
      end
      S_ROUND: begin
        // Wait until the output register is free or is being emptied.
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CSM_ASSERT(a_finish_free, clk, rst, cmd.finish |-> out_free, "finish overwrote an item")
  `CSM_ASSERT(a_nonzero_mul, clk, rst, cmd.vec_read |=> cmd.mul, "nonzero skipped multiply")
  `CSM_ASSERT(a_valid_rise, clk, rst, $rose(out_valid) |-> $past(cmd.finish), "stray valid")
  `CSM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!out_valid && !in_stall), "not idle after reset")

endmodule
